/* rtl/core/lmts_pkg.sv */
`default_nettype none
// ============================================================================
// LED matrix text scroller package
// Shared constants, the command and status structs, the controller state
// type and the 5x7 font table.
// ============================================================================
package lmts_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;

    localparam int GLYPH_COUNT  = 30;
    localparam int GLYPH_WIDTH  = 5;
    localparam int CHAR_COLUMNS = GLYPH_WIDTH + 1;
    localparam int WINDOW       = 8;

    localparam logic [4:0] GLYPH_BLANK  = 5'd26;
    localparam logic [4:0] GLYPH_DASH   = 5'd27;
    localparam logic [4:0] GLYPH_COLON  = 5'd28;
    localparam logic [4:0] GLYPH_EQUALS = 5'd29;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    localparam logic [3:0] STEP_GLYPH_END = 4'd5;
    localparam logic [3:0] STEP_READ_END  = 4'd8;
    localparam logic [3:0] STEP_ROW_END   = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_ROWS,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_glyph;
        logic clear;
        logic step_clr;
        logic step_inc;
        logic wr;
        logic cap;
        logic emit_row;
        logic emit_fin;
        logic pos_inc;
    } t_cmd;

    typedef struct packed {
        logic [3:0] step;
        logic       full;
        logic       at_end;
        logic       out_free;
    } t_status;

    // column 0 in the top byte
    localparam logic [39:0] FONT [GLYPH_COUNT] = '{
        40'h7E0909097E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141413E,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h0000000000, 40'h0808080808,
        40'h0800080000, 40'h1414141414
    };

    function automatic logic [4:0] glyph_index(input logic [7:0] code);
        logic [7:0] rel;
        rel = code - 8'd65;
        if (code >= 8'd65 && code <= 8'd90) begin
            return rel[4:0];
        end else if (code == 8'd45) begin
            return GLYPH_DASH;
        end else if (code == 8'd58) begin
            return GLYPH_COLON;
        end else if (code == 8'd61) begin
            return GLYPH_EQUALS;
        end
        return GLYPH_BLANK;
    endfunction

    function automatic logic [7:0] glyph_column(input logic [4:0] g, input logic [2:0] j);
        logic [39:0] glyph;
        glyph = (int'(g) < GLYPH_COUNT) ? FONT[g] : 40'd0;
        if (int'(j) >= GLYPH_WIDTH) begin
            return 8'h00;
        end
        return glyph[39 - 8 * int'(j) -: 8];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lmts_ctrl.sv */
`default_nettype none
// ============================================================================
// LED matrix text scroller controller
// Decodes the item kind and sequences glyph writes, window reads and row
// emission through commands to the datapath.
// ============================================================================
module lmts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_kind,
    input  wire lmts_pkg::t_status i_status,
    output lmts_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);

    lmts_pkg::t_state r_state;
    lmts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        lmts_pkg::KIND_LOAD: begin
                            if (!i_status.full) n_state = lmts_pkg::ST_LOAD;
                        end
                        lmts_pkg::KIND_TICK: begin
                            n_state = i_status.at_end ? lmts_pkg::ST_FIN
                                                      : lmts_pkg::ST_READ;
                        end
                        default: n_state = lmts_pkg::ST_IDLE;
                    endcase
                end
            end
            lmts_pkg::ST_LOAD: begin
                if (i_status.step == lmts_pkg::STEP_GLYPH_END) n_state = lmts_pkg::ST_IDLE;
            end
            lmts_pkg::ST_READ: begin
                if (i_status.step == lmts_pkg::STEP_READ_END) n_state = lmts_pkg::ST_ROWS;
            end
            lmts_pkg::ST_ROWS: begin
                if (i_status.out_free && i_status.step == lmts_pkg::STEP_ROW_END) begin
                    n_state = lmts_pkg::ST_IDLE;
                end
            end
            lmts_pkg::ST_FIN: begin
                if (i_status.out_free) n_state = lmts_pkg::ST_IDLE;
            end
            default: n_state = lmts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            lmts_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    unique case (i_kind)
                        lmts_pkg::KIND_LOAD: begin
                            o_cmd.load_glyph = 1'b1;
                            o_cmd.step_clr   = 1'b1;
                        end
                        lmts_pkg::KIND_TICK: o_cmd.step_clr = 1'b1;
                        lmts_pkg::KIND_STOP: o_cmd.clear    = 1'b1;
                        default: o_cmd = '0;
                    endcase
                end
            end
            lmts_pkg::ST_LOAD: begin
                o_cmd.wr       = 1'b1;
                o_cmd.step_inc = 1'b1;
            end
            lmts_pkg::ST_READ: begin
                o_cmd.cap      = (i_status.step != 4'd0);
                o_cmd.step_inc = 1'b1;
                o_cmd.step_clr = (i_status.step == lmts_pkg::STEP_READ_END);
            end
            lmts_pkg::ST_ROWS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    o_cmd.step_inc = 1'b1;
                    o_cmd.pos_inc  = (i_status.step == lmts_pkg::STEP_ROW_END);
                end
            end
            lmts_pkg::ST_FIN: o_cmd.emit_fin = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/lmts_dp.sv */
`default_nettype none
// ============================================================================
// LED matrix text scroller datapath
// Column store, count and position registers, window buffer, row
// transpose and output register.
// ============================================================================
module lmts_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_char_code,
    input  wire lmts_pkg::t_cmd i_cmd,
    input  wire logic          i_out_stall,
    output lmts_pkg::t_status  o_status,
    output logic               o_out_valid,
    output logic [3:0]         o_row_address,
    output logic [7:0]         o_row_bits,
    output logic               o_finished,
    output logic               o_last
);

    logic [7:0] r_mem [lmts_pkg::MAX_COLUMNS];
    logic [7:0] r_rd_data;
    logic [7:0] r_win [lmts_pkg::WINDOW];

    logic [lmts_pkg::CNT_W-1:0] r_count;
    logic [lmts_pkg::CNT_W-1:0] r_pos;
    logic [4:0]                 r_glyph;
    logic [3:0]                 r_step;

    logic                       r_out_valid;
    logic [3:0]                 r_row_address;
    logic [7:0]                 r_row_bits;
    logic                       r_finished;
    logic                       r_last;

    logic [lmts_pkg::CNT_W:0]   w_end_sum;
    logic [lmts_pkg::CNT_W:0]   w_fill_sum;
    logic [lmts_pkg::CNT_W-1:0] w_rd_sum;
    logic [lmts_pkg::COL_W-1:0] w_rd_addr;
    logic [2:0]                 w_row;
    logic [7:0]                 w_row_bits;
    logic                       w_out_free;

    assign w_end_sum  = {1'b0, r_pos} + (lmts_pkg::CNT_W+1)'(lmts_pkg::WINDOW);
    assign w_fill_sum = {1'b0, r_count} + (lmts_pkg::CNT_W+1)'(lmts_pkg::CHAR_COLUMNS);
    assign w_rd_sum   = r_pos + lmts_pkg::CNT_W'(r_step);
    assign w_rd_addr  = w_rd_sum[lmts_pkg::COL_W-1:0];
    assign w_row      = r_step[2:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int b = 0; b < lmts_pkg::WINDOW; b++) begin
            w_row_bits[b] = r_win[b][w_row];
        end
    end

    assign o_status.step     = r_step;
    assign o_status.full     = w_fill_sum > (lmts_pkg::CNT_W+1)'(lmts_pkg::MAX_COLUMNS);
    assign o_status.at_end   = w_end_sum >= {1'b0, r_count};
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_count[lmts_pkg::COL_W-1:0]] <= lmts_pkg::glyph_column(r_glyph, r_step[2:0]);
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // shift in so the first column read ends at window column 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            for (int i = 0; i < lmts_pkg::WINDOW - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[lmts_pkg::WINDOW-1] <= r_rd_data;
        end
        if (i_cmd.load_glyph) begin
            r_glyph <= lmts_pkg::glyph_index(i_char_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
            r_step  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_pos   <= '0;
            end else begin
                if (i_cmd.wr) r_count <= r_count + 1'b1;
                if (i_cmd.pos_inc) r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.step_clr) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_row || i_cmd.emit_fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_row) begin
            r_row_address <= {1'b0, w_row} + 4'd1;
            r_row_bits    <= w_row_bits;
            r_finished    <= 1'b0;
            r_last        <= (r_step == lmts_pkg::STEP_ROW_END);
        end else if (i_cmd.emit_fin) begin
            r_row_address <= 4'd0;
            r_row_bits    <= 8'h00;
            r_finished    <= 1'b1;
            r_last        <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_address = r_row_address;
    assign o_row_bits    = r_row_bits;
    assign o_finished    = r_finished;
    assign o_last        = r_last;

endmodule
`default_nettype wire

/* rtl/core/led_matrix_text_scroller.sv */
`default_nettype none
// ============================================================================
// LED matrix text scroller
// Builds a column store from 5x7 glyphs; a tick turns the 8-column window
// at the scroll position into eight row writes, or a finished result at end.
// ============================================================================
// A load item is accepted and then makes six single-port column writes,
// or is dropped at accept when the store is full. A stop item and an
// unknown kind are taken at accept alone. A tick is accepted, reads the
// eight window columns through the registered store port, then puts
// eight row results into the output register, holding while the output
// stalls; a finished tick puts one finished result there. The output
// register lets the next item be accepted while the last result waits.
module led_matrix_text_scroller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_char_code,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_row_address,
    output logic [7:0]      o_row_bits,
    output logic            o_finished,
    output logic            o_last
);

    lmts_pkg::t_cmd    w_cmd;
    lmts_pkg::t_status w_status;
    logic              w_busy;

    lmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    lmts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_code   (i_char_code),
        .i_cmd         (w_cmd),
        .i_out_stall   (i_out_stall),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_row_address (o_row_address),
        .o_row_bits    (o_row_bits),
        .o_finished    (o_finished),
        .o_last        (o_last)
    );

    assign o_in_stall = w_busy;

endmodule
`default_nettype wire

/* dv/tb_led_matrix_text_scroller.sv */
`timescale 1ns / 1ps
// ============================================================================
// LED matrix text scroller testbench
// Sends load, tick, stop and unknown items with random gaps on both channels.
// A local model of the column store predicts each row write and finished
// result that no directed item lists. Each result is checked in order.
// ============================================================================
module tb_led_matrix_text_scroller;

    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int HALF_PERIOD  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 80;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef struct packed {
        logic [3:0] row_address;
        logic [7:0] row_bits;
        logic       finished;
        logic       last;
    } t_row;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       typed;
        t_row       res;
    } t_stim;

    localparam t_row FIN_ROW = {4'd0, 8'h00, 1'b1, 1'b1};
    localparam t_row NO_ROW  = '0;

    localparam t_stim DIRECTED [24] = '{
        {lmts_pkg::KIND_TICK, 8'h00, 1'b1, FIN_ROW},
        {KIND_NONE, 8'hFF, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h41, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h00, 1'b1, FIN_ROW},
        {lmts_pkg::KIND_LOAD, 8'h5A, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'hFF, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h2D, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h3A, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h3D, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'hFF, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h40, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h5B, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'hAA, 1'b0, NO_ROW},
        {KIND_NONE, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h55, 1'b0, NO_ROW},
        {lmts_pkg::KIND_STOP, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h00, 1'b1, FIN_ROW},
        {lmts_pkg::KIND_LOAD, 8'h4D, 1'b0, NO_ROW},
        {lmts_pkg::KIND_LOAD, 8'h57, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_TICK, 8'h00, 1'b0, NO_ROW},
        {lmts_pkg::KIND_STOP, 8'hFF, 1'b0, NO_ROW}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_kind      = lmts_pkg::KIND_LOAD;
    logic [7:0] i_char_code = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [3:0] o_row_address;
    logic [7:0] o_row_bits;
    logic       o_finished;
    logic       o_last;

    logic [7:0] store_cols [lmts_pkg::MAX_COLUMNS];
    int         text_cols  = 0;
    int         window_pos = 0;
    t_row       rows_expected [$];

    bit long_hold = 1'b0;
    bit no_idle   = 1'b0;

    int items_sent     = 0;
    int rows_checked   = 0;
    int ticks_finished = 0;
    int loads_dropped  = 0;
    int mismatch_count = 0;
    int leftover       = 0;

    led_matrix_text_scroller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_address (o_row_address),
        .o_row_bits    (o_row_bits),
        .o_finished    (o_finished),
        .o_last        (o_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int glyph_of_code(input logic [7:0] code);
        if (code >= "A" && code <= "Z") begin
            return int'(code - "A");
        end else if (code == "-") begin
            return int'(lmts_pkg::GLYPH_DASH);
        end else if (code == ":") begin
            return int'(lmts_pkg::GLYPH_COLON);
        end else if (code == "=") begin
            return int'(lmts_pkg::GLYPH_EQUALS);
        end
        return int'(lmts_pkg::GLYPH_BLANK);
    endfunction

    // column 0 in the top byte
    function automatic logic [39:0] glyph_font(input int g);
        case (g)
            0:  return 40'h7E0909097E;
            1:  return 40'h7F49494936;
            2:  return 40'h3E41414122;
            3:  return 40'h7F4141413E;
            4:  return 40'h7F49494941;
            5:  return 40'h7F09090901;
            6:  return 40'h3E4149497A;
            7:  return 40'h7F0808087F;
            8:  return 40'h00417F4100;
            9:  return 40'h2040413F01;
            10: return 40'h7F08142241;
            11: return 40'h7F40404040;
            12: return 40'h7F0204027F;
            13: return 40'h7F0408107F;
            14: return 40'h3E4141413E;
            15: return 40'h7F09090906;
            16: return 40'h3E4151215E;
            17: return 40'h7F09192946;
            18: return 40'h4649494931;
            19: return 40'h01017F0101;
            20: return 40'h3F4040403F;
            21: return 40'h1F2040201F;
            22: return 40'h7F2018207F;
            23: return 40'h6314081463;
            24: return 40'h0708700807;
            25: return 40'h6151494543;
            int'(lmts_pkg::GLYPH_DASH):   return 40'h0808080808;
            int'(lmts_pkg::GLYPH_COLON):  return 40'h0800080000;
            int'(lmts_pkg::GLYPH_EQUALS): return 40'h1414141414;
            default: return 40'h0000000000;
        endcase
    endfunction

    function automatic void scroll_predict(input logic [1:0] kind, input logic [7:0] code,
                                           input bit keep);
        logic [39:0] glyph;
        t_row        r;
        int          row;
        int          b;
        case (kind)
            lmts_pkg::KIND_LOAD: begin
                if (text_cols + lmts_pkg::CHAR_COLUMNS > lmts_pkg::MAX_COLUMNS) begin
                    loads_dropped++;
                end else begin
                    glyph = glyph_font(glyph_of_code(code));
                    for (int j = 0; j < lmts_pkg::GLYPH_WIDTH; j++) begin
                        store_cols[text_cols + j] = glyph[39 - 8 * j -: 8];
                    end
                    store_cols[text_cols + lmts_pkg::GLYPH_WIDTH] = 8'h00;
                    text_cols += lmts_pkg::CHAR_COLUMNS;
                end
            end
            lmts_pkg::KIND_STOP: begin
                text_cols  = 0;
                window_pos = 0;
            end
            lmts_pkg::KIND_TICK: begin
                if (window_pos + lmts_pkg::WINDOW >= text_cols) begin
                    ticks_finished++;
                    if (keep) rows_expected.push_back(FIN_ROW);
                end else begin
                    for (row = 0; row < lmts_pkg::WINDOW; row++) begin
                        r = NO_ROW;
                        r.row_address = 4'(row + 1);
                        for (b = 0; b < lmts_pkg::WINDOW; b++) begin
                            r.row_bits[b] = store_cols[window_pos + b][row];
                        end
                        r.last = (row == lmts_pkg::WINDOW - 1);
                        if (keep) rows_expected.push_back(r);
                    end
                    window_pos++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return 8'("A" + $urandom_range(0, 25));
        if (sel == 5) begin
            case ($urandom_range(0, 2))
                0: return "-";
                1: return ":";
                default: return "=";
            endcase
        end
        if (sel == 6) return " ";
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                             input logic typed, input t_row res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_char_code <= code;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (typed) rows_expected.push_back(res);
        scroll_predict(kind, code, !typed);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (rows_expected.size() != 0);
    endtask

    always @(posedge i_clk) begin : check_rows
        t_row got;
        t_row want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got = {o_row_address, o_row_bits, o_finished, o_last};
            if (rows_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected row: addr %0d bits %02h finished %0b last %0b",
                             got.row_address, got.row_bits, got.finished, got.last);
                end
            end else begin
                want = rows_expected.pop_front();
                rows_checked++;
                if (got.row_address !== want.row_address || got.row_bits !== want.row_bits ||
                    got.finished !== want.finished || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("row mismatch: exp addr %0d bits %02h fin %0b last %0b",
                                 want.row_address, want.row_bits, want.finished, want.last);
                        $display("              got addr %0d bits %02h fin %0b last %0b",
                                 got.row_address, got.row_bits, got.finished, got.last);
                    end
                end
            end
        end
    end

    initial begin : rx_side
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                long_hold = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin : tx_side
        int i;
        int r;
        int session;
        int random_sent;
        int n_chars;
        int n_ticks;
        random_sent = 0;
        session = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(DIRECTED); i++) begin
            send_item(DIRECTED[i].kind, DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].res);
        end
        wait_for_results();

        while (random_sent < RANDOM_ITEMS) begin
            no_idle = (session == 2);
            send_item(lmts_pkg::KIND_STOP, 8'($urandom_range(0, 255)), 1'b0, NO_ROW);
            random_sent++;
            n_chars = (session == 0) ? 44 : (session == 1) ? 4 : $urandom_range(1, 5);
            for (i = 0; i < n_chars; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(KIND_NONE, 8'($urandom_range(0, 255)), 1'b0, NO_ROW);
                end
                send_item(lmts_pkg::KIND_LOAD, pick_code(), 1'b0, NO_ROW);
                random_sent++;
            end
            n_ticks = (text_cols > window_pos + lmts_pkg::WINDOW)
                    ? text_cols - lmts_pkg::WINDOW - window_pos : 0;
            if (n_ticks > 12) n_ticks = 12;
            n_ticks += $urandom_range(1, 2);
            if (session == 1) long_hold = 1'b1;
            for (i = 0; i < n_ticks; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_item(lmts_pkg::KIND_STOP, 8'($urandom_range(0, 255)), 1'b0, NO_ROW);
                end else if (r == 1) begin
                    send_item(lmts_pkg::KIND_LOAD, pick_code(), 1'b0, NO_ROW);
                end else begin
                    send_item(lmts_pkg::KIND_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_ROW);
                end
                random_sent++;
            end
            if (session == 1) wait_for_results();
            session++;
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        for (i = 0; i < DRAIN_LIMIT && rows_expected.size() != 0; i++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        leftover = rows_expected.size();

        $display("covered %0d items in %0d sessions: %0d rows checked, %0d finished ticks",
                 items_sent, session, rows_checked, ticks_finished);
        $display("characters dropped on a full store: %0d, mismatches %0d, unmatched %0d",
                 loads_dropped, mismatch_count, leftover);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lmts_pkg.sv
rtl/core/lmts_ctrl.sv
rtl/core/lmts_dp.sv
rtl/core/led_matrix_text_scroller.sv
dv/tb_led_matrix_text_scroller.sv
